### hw/rtl/bgpc_pkg.sv
// Shared types and constants of the button gesture player control block.
`default_nettype none
package bgpc_pkg;

	localparam int BTN_N = 5;
	localparam int EV_W = 11;
	localparam int CFG_W = 20;
	localparam int TIME_W = 32;

	localparam int MAX_TRACKS = 256;
	localparam int TRK_CAP_I = (MAX_TRACKS > 256) ? 256 : MAX_TRACKS;
	localparam logic [8:0] TRK_CAP = 9'(TRK_CAP_I);

	localparam logic [6:0] VOL_MAX = 7'd100;
	localparam logic [6:0] VOL_STEP = 7'd5;
	localparam logic [6:0] VOL_RESET = 7'd30;

	// button positions in button_levels
	localparam int BTN_VUP = 0;
	localparam int BTN_VDN = 1;
	localparam int BTN_BACK = 2;
	localparam int BTN_FWD = 3;
	localparam int BTN_PAUSE = 4;

	// event_mask bits
	localparam int EV_VOL_UP = 0;
	localparam int EV_VOL_DN = 1;
	localparam int EV_RAMP = 2;
	localparam int EV_PREV = 3;
	localparam int EV_NEXT = 4;
	localparam int EV_PLAY = 5;
	localparam int EV_PAUSE = 6;
	localparam int EV_SKIP = 7;
	localparam int EV_LOOP = 8;
	localparam int EV_AUTOSAVE = 9;
	localparam int EV_RAMP_END = 10;

	typedef enum logic [2:0] {
		CFG_DEBOUNCE,
		CFG_LONG_PRESS,
		CFG_DOUBLE_CLICK,
		CFG_COMBO_HOLD,
		CFG_COMBO_WAIT,
		CFG_RAMP_INTERVAL,
		CFG_AUTOSAVE,
		CFG_PLAYLIST
	} cfg_idx_t;

	typedef struct packed {
		logic [9:0]  settle_ms;
		logic [13:0] hold_ramp_ms;
		logic [12:0] dbl_tap_ms;
		logic [13:0] combo_hold_ms;
		logic [9:0]  combo_wait_ms;
		logic [9:0]  ramp_interval_ms;
		logic [19:0] autosave_ms;
		logic [8:0]  playlist_size;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		settle_ms:        10'd50,
		hold_ramp_ms:     14'd800,
		dbl_tap_ms:       13'd400,
		combo_hold_ms:    14'd500,
		combo_wait_ms:    10'd50,
		ramp_interval_ms: 10'd60,
		autosave_ms:      20'd10000,
		playlist_size:    9'd1
	};

	// classified tick passed from front to back
	typedef struct packed {
		logic [BTN_N-1:0]  lv;
		logic [BTN_N-1:0]  rise;
		logic [TIME_W-1:0] now;
	} item_t;

	typedef struct packed {
		logic [6:0]      volume;
		logic [7:0]      track;
		logic            playing;
		logic            repeat_one;
		logic            track_changed;
		logic            save_request;
		logic [EV_W-1:0] event_mask;
	} res_t;

endpackage
`default_nettype wire

### hw/rtl/bgpc_front.sv
// Front end: accepts ticks, stamps the ms time and finds rising button edges.
`default_nettype none
module bgpc_front
	import bgpc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [BTN_N-1:0] button_levels,
	input  wire logic             q_full,
	output logic                  push,
	output item_t                 item
);

	logic [BTN_N-1:0]  prev_q;
	logic [TIME_W-1:0] ms_q;

	assign in_stall  = q_full;
	assign push      = in_valid && !q_full;
	assign item.lv   = button_levels;
	assign item.rise = button_levels & ~prev_q;
	assign item.now  = ms_q + TIME_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			ms_q   <= '0;
		end else if (push) begin
			prev_q <= button_levels;
			ms_q   <= item.now;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/bgpc_queue.sv
// Short item queue between front and back ends.
`default_nettype none
module bgpc_queue
	import bgpc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t wr_item,
	output logic       full,
	input  wire logic  pop,
	output logic       rd_valid,
	output item_t      rd_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/bgpc_back.sv
// Back end: gesture, volume, track, save; one tick per cycle unless held.
`default_nettype none
module bgpc_back
	import bgpc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  red_start,
	input  wire logic  q_valid,
	input  wire item_t q_item,
	output logic       q_pop,
	output logic       out_valid,
	input  wire logic  out_stall,
	output res_t       res
);

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_HOLD,
		CS_TOGGLED
	} combo_t;

	logic [TIME_W-1:0] apt_q [BTN_N];
	logic [BTN_N-1:0]  pend_q;
	logic [1:0]        long_q;
	logic [6:0]        vol_q;
	logic [7:0]        trk_q;
	logic [7:0]        tred_q;
	logic              loop_q;
	logic              play_q;
	logic [TIME_W-1:0] lpt_q;
	logic [TIME_W-1:0] cst_q;
	combo_t            combo_q;
	logic [TIME_W-1:0] ramp_q;
	logic [TIME_W-1:0] save_q;
	logic [TIME_W-1:0] wst_q;
	logic              out_valid_q;
	res_t              res_q;

	// track index remainder pass after a playlist size write
	logic              red_busy_q;
	logic [2:0]        red_cnt_q;
	logic [7:0]        rem_q;
	logic [8:0]        rem_sh;
	logic [8:0]        rem_nx;

	logic [8:0]        n9;
	logic [7:0]        nm1;

	logic [TIME_W-1:0] apt_n [BTN_N];
	logic [BTN_N-1:0]  pend_n;
	logic [1:0]        long_n;
	logic [6:0]        vol_v;
	logic [7:0]        tred_v;
	logic [7:0]        trk_v;
	logic              loop_v;
	logic              play_v;
	logic [TIME_W-1:0] lpt_n;
	logic [TIME_W-1:0] cst_n;
	combo_t            combo_n;
	logic [TIME_W-1:0] ramp_n;
	logic [TIME_W-1:0] save_n;
	logic [TIME_W-1:0] wst_n;
	logic [EV_W-1:0]   ev;
	logic              tchg;
	logic              save;
	logic              block;
	logic              stepped;
	logic              due;
	logic              wait_done;
	logic              both;
	logic              any;
	logic [TIME_W-1:0] now;
	res_t              res_n;

	function automatic logic [7:0] trk_inc(logic [7:0] r, logic [7:0] top);
		return (r == top) ? 8'd0 : r + 8'd1;
	endfunction

	function automatic logic [7:0] trk_dec(logic [7:0] r, logic [7:0] top);
		return (r == 8'd0) ? top : r - 8'd1;
	endfunction

	always_comb begin
		n9 = cfg.playlist_size;
		if (n9 == 9'd0) begin
			n9 = 9'd1;
		end
		if (n9 > TRK_CAP) begin
			n9 = TRK_CAP;
		end
	end
	assign nm1 = 8'(n9 - 9'd1);

	assign rem_sh = {rem_q, trk_q[~red_cnt_q]};
	assign rem_nx = (rem_sh >= n9) ? rem_sh - n9 : rem_sh;

	assign q_pop     = q_valid && !red_busy_q && !red_start && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign res       = res_q;
	assign now       = q_item.now;
	assign both      = (q_item.lv[BTN_FWD:BTN_BACK] == 2'b11);
	assign any       = (q_item.lv[BTN_FWD:BTN_BACK] != 2'b00);

	always_comb begin
		pend_n    = pend_q;
		apt_n     = apt_q;
		wst_n     = wst_q;
		long_n    = long_q;
		vol_v     = vol_q;
		tred_v    = tred_q;
		trk_v     = trk_q;
		loop_v    = loop_q;
		play_v    = play_q;
		lpt_n     = lpt_q;
		cst_n     = cst_q;
		combo_n   = combo_q;
		ramp_n    = ramp_q;
		save_n    = save_q;
		ev        = '0;
		tchg      = 1'b0;
		save      = 1'b0;
		block     = 1'b0;
		stepped   = 1'b0;
		due       = 1'b0;
		wait_done = 1'b0;

		// debounce and edge capture
		for (int i = 0; i < BTN_N; i++) begin
			if (q_item.rise[i] && (now - apt_q[i]) > TIME_W'(cfg.settle_ms)) begin
				pend_n[i] = 1'b1;
				apt_n[i]  = now;
				if (i == BTN_BACK || i == BTN_FWD) begin
					wst_n = now;
				end
			end
		end

		// prev + next combo
		case (combo_q)
			CS_TOGGLED: begin
				block = 1'b1;
				if (!any) begin
					pend_n[BTN_BACK] = 1'b0;
					pend_n[BTN_FWD]  = 1'b0;
					combo_n          = CS_IDLE;
				end
			end
			CS_HOLD: begin
				if (both) begin
					block = 1'b1;
					if ((now - cst_q) > TIME_W'(cfg.combo_hold_ms)) begin
						loop_v           = !loop_q;
						ev[EV_LOOP]      = 1'b1;
						save             = 1'b1;
						pend_n[BTN_BACK] = 1'b0;
						pend_n[BTN_FWD]  = 1'b0;
						combo_n          = CS_TOGGLED;
					end
				end else begin
					combo_n = CS_IDLE;
				end
			end
			default: begin
				if (both) begin
					combo_n = CS_HOLD;
					cst_n   = now;
					block   = 1'b1;
				end
			end
		endcase

		if (!block) begin
			// long press ramp
			due = (now - ramp_q) >= TIME_W'(cfg.ramp_interval_ms);
			for (int i = 0; i < 2; i++) begin
				if (q_item.lv[i]) begin
					if ((now - apt_n[i]) > TIME_W'(cfg.hold_ramp_ms)) begin
						long_n[i] = 1'b1;
						if (due) begin
							if (i == BTN_VUP) begin
								if (vol_v < VOL_MAX) begin
									vol_v = vol_v + 7'd1;
								end
							end else if (vol_v != 7'd0) begin
								vol_v = vol_v - 7'd1;
							end
							stepped = 1'b1;
						end
					end
				end else if (long_q[i]) begin
					long_n[i]      = 1'b0;
					ev[EV_RAMP_END] = 1'b1;
					save           = 1'b1;
				end
			end
			if (stepped) begin
				ramp_n      = now;
				ev[EV_RAMP] = 1'b1;
			end

			// pending presses
			wait_done = (now - wst_n) >= TIME_W'(cfg.combo_wait_ms);
			if (pend_n[BTN_VUP]) begin
				pend_n[BTN_VUP] = 1'b0;
				if (!long_n[BTN_VUP]) begin
					vol_v = (vol_v > VOL_MAX - VOL_STEP) ? VOL_MAX : vol_v + VOL_STEP;
					ev[EV_VOL_UP] = 1'b1;
					save = 1'b1;
				end
			end
			if (pend_n[BTN_VDN]) begin
				pend_n[BTN_VDN] = 1'b0;
				if (!long_n[BTN_VDN]) begin
					vol_v = (vol_v < VOL_STEP) ? 7'd0 : vol_v - VOL_STEP;
					ev[EV_VOL_DN] = 1'b1;
					save = 1'b1;
				end
			end
			if (pend_n[BTN_BACK] && wait_done) begin
				pend_n[BTN_BACK] = 1'b0;
				tred_v           = trk_dec(tred_v, nm1);
				tchg             = 1'b1;
				ev[EV_PREV]      = 1'b1;
			end
			if (pend_n[BTN_FWD] && wait_done) begin
				pend_n[BTN_FWD] = 1'b0;
				tred_v          = trk_inc(tred_v, nm1);
				tchg            = 1'b1;
				ev[EV_NEXT]     = 1'b1;
			end
			if (pend_n[BTN_PAUSE]) begin
				pend_n[BTN_PAUSE] = 1'b0;
				if ((now - lpt_q) < TIME_W'(cfg.dbl_tap_ms)) begin
					tred_v      = trk_inc(tred_v, nm1);
					tchg        = 1'b1;
					ev[EV_SKIP] = 1'b1;
				end else begin
					play_v = !play_q;
					if (play_v) begin
						ev[EV_PLAY] = 1'b1;
					end else begin
						ev[EV_PAUSE] = 1'b1;
					end
					save = 1'b1;
				end
				lpt_n = now;
			end
			if (tchg) begin
				trk_v = tred_v;
			end

			// autosave
			if ((now - save_q) > TIME_W'(cfg.autosave_ms)) begin
				save            = 1'b1;
				save_n          = now;
				ev[EV_AUTOSAVE] = 1'b1;
			end
		end

		res_n.volume        = vol_v;
		res_n.track         = trk_v;
		res_n.playing       = play_v;
		res_n.repeat_one    = loop_v;
		res_n.track_changed = tchg;
		res_n.save_request  = save;
		res_n.event_mask    = ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BTN_N; i++) begin
				apt_q[i] <= '0;
			end
			pend_q      <= '0;
			long_q      <= '0;
			vol_q       <= VOL_RESET;
			trk_q       <= '0;
			tred_q      <= '0;
			loop_q      <= 1'b0;
			play_q      <= 1'b0;
			lpt_q       <= '0;
			cst_q       <= '0;
			combo_q     <= CS_IDLE;
			ramp_q      <= '0;
			save_q      <= '0;
			wst_q       <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
			red_busy_q  <= 1'b0;
			red_cnt_q   <= '0;
			rem_q       <= '0;
		end else begin
			if (red_start) begin
				red_busy_q <= 1'b1;
				red_cnt_q  <= '0;
				rem_q      <= '0;
			end else if (red_busy_q) begin
				rem_q     <= rem_nx[7:0];
				red_cnt_q <= red_cnt_q + 3'd1;
				if (red_cnt_q == 3'd7) begin
					red_busy_q <= 1'b0;
					tred_q     <= rem_nx[7:0];
				end
			end

			if (q_pop) begin
				apt_q       <= apt_n;
				pend_q      <= pend_n;
				long_q      <= long_n;
				vol_q       <= vol_v;
				trk_q       <= trk_v;
				tred_q      <= tred_v;
				loop_q      <= loop_v;
				play_q      <= play_v;
				lpt_q       <= lpt_n;
				cst_q       <= cst_n;
				combo_q     <= combo_n;
				ramp_q      <= ramp_n;
				save_q      <= save_n;
				wst_q       <= wst_n;
				res_q       <= res_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/button_gesture_player_control_top.sv
// Top level of the button gesture player control block.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  in      | input     | in_valid / in_stall   | button_levels
//  out     | output    | out_valid / out_stall | volume, track, playing, repeat_one,
//          |           |                      | track_changed, save_request, event_mask
//  cfg     | input     | cfg_we               | cfg_index, cfg_wdata
//
//  One tick is taken every cycle while in_stall is low; it passes the queue and the back end
//  output register. The back end works a tick combinationally; the queue absorbs output
//  stalls. A playlist_size write holds the back end for the write cycle and a remainder pass
//  over the track index; ticks queue up meanwhile and in_stall rises once it is full.
//  Reset returns volume 30, track 0, paused, repeat_one off, registers to their defaults.
`default_nettype none
module button_gesture_player_control_top
	import bgpc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [BTN_N-1:0] button_levels,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [6:0]            volume,
	output logic [7:0]            track,
	output logic                  playing,
	output logic                  repeat_one,
	output logic                  track_changed,
	output logic                  save_request,
	output logic [EV_W-1:0]       event_mask,
	input  wire logic             cfg_we,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_wdata
);

	cfg_t  cfg_q;
	logic  push;
	logic  q_full;
	logic  q_pop;
	logic  q_valid;
	item_t f_item;
	item_t q_item;
	res_t  res;
	logic  red_start;

	assign red_start = cfg_we && (cfg_index == CFG_PLAYLIST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEBOUNCE:      cfg_q.settle_ms        <= 10'(cfg_wdata);
				CFG_LONG_PRESS:    cfg_q.hold_ramp_ms     <= 14'(cfg_wdata);
				CFG_DOUBLE_CLICK:  cfg_q.dbl_tap_ms       <= 13'(cfg_wdata);
				CFG_COMBO_HOLD:    cfg_q.combo_hold_ms    <= 14'(cfg_wdata);
				CFG_COMBO_WAIT:    cfg_q.combo_wait_ms    <= 10'(cfg_wdata);
				CFG_RAMP_INTERVAL: cfg_q.ramp_interval_ms <= 10'(cfg_wdata);
				CFG_AUTOSAVE:      cfg_q.autosave_ms      <= 20'(cfg_wdata);
				CFG_PLAYLIST:      cfg_q.playlist_size    <= 9'(cfg_wdata);
				default: begin
				end
			endcase
		end
	end

	bgpc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.button_levels (button_levels),
		.q_full        (q_full),
		.push          (push),
		.item          (f_item)
	);

	bgpc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_item  (f_item),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_item  (q_item)
	);

	bgpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.red_start (red_start),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign volume        = res.volume;
	assign track         = res.track;
	assign playing       = res.playing;
	assign repeat_one    = res.repeat_one;
	assign track_changed = res.track_changed;
	assign save_request  = res.save_request;
	assign event_mask    = res.event_mask;

	a_vol_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (volume <= VOL_MAX))
		else $error("volume above maximum");

	a_play_pause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(event_mask[EV_PLAY] && event_mask[EV_PAUSE]))
		else $error("play and pause in one item");

	a_track_chg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (track_changed ==
			(event_mask[EV_PREV] || event_mask[EV_NEXT] || event_mask[EV_SKIP])))
		else $error("track_changed disagrees with event mask");

	a_save: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (save_request == (event_mask[EV_VOL_UP] || event_mask[EV_VOL_DN]
			|| event_mask[EV_PLAY] || event_mask[EV_PAUSE] || event_mask[EV_LOOP]
			|| event_mask[EV_AUTOSAVE] || event_mask[EV_RAMP_END])))
		else $error("save_request disagrees with event mask");

	a_no_pop_reduce: assert property (@(posedge clk) disable iff (!arst_n)
		red_start |=> !q_pop)
		else $error("item taken during track remainder pass");

endmodule
`default_nettype wire
